// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the timer rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mspt_pkg.sv =====
// shared types and codes of the multi-slot timer
// used by mspt_ctrl, mspt_dpath and the top level
package mspt_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int TIME_BITS_DEF = 32;

   localparam logic [2:0] ACT_TICK         = 3'd0;
   localparam logic [2:0] ACT_ARM_ONCE     = 3'd1;
   localparam logic [2:0] ACT_ARM_PERIODIC = 3'd2;
   localparam logic [2:0] ACT_CLEAR        = 3'd3;
   localparam logic [2:0] ACT_PAUSE        = 3'd4;
   localparam logic [2:0] ACT_RESUME       = 3'd5;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] period_ticks;
      logic [3:0]  slot_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot_id;
      logic [31:0] elapsed_ticks;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       tick;
      logic       clear_slot;
      logic       set_pause;
      logic       clr_pause;
      logic       arm_write;
      logic       idx_next;
      logic       scan_fire;
      logic       out_load;
      logic       out_from_hold;
      logic       out_last;
      logic [1:0] out_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       paused;
      logic       cur_valid;
      logic       expired;
      logic       idx_last;
      logic       hold_valid;
      logic       out_free;
   } ctl_sts_type;

endpackage

// ===== hw/rtl/multi_slot_oneshot_periodic_timer.sv =====
// Multi-slot one-shot / periodic timer. Requests are taken one at a time: a tick walks
// the slot table one slot per clock, except while a held-back result waits on rsp_stall,
// through the single read port of the deadline and period memories; a paused tick ends
// at decode. An arm walks the valid bits to the lowest free slot; clear, pause and resume
// go from decode to a response, and unused action codes return to idle from decode. Each
// response waits while rsp_stall holds the output. A tick that fires holds back its newest
// result so that the final one carries last; a new request is taken while a result still
// waits in the output register. No clearing pass runs after reset.
// top level; depends on mspt_pkg, mspt_ctrl and mspt_dpath
module multi_slot_oneshot_periodic_timer #(
   parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = mspt_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mspt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mspt_pkg::rsp_type rsp_data
);
   import mspt_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mspt_dpath #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== hw/rtl/mspt_ctrl.sv =====
// sequencing state machine of the multi-slot timer
// depends on mspt_pkg and assert_macros.svh; drives mspt_dpath by commands
`include "assert_macros.svh"

module mspt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mspt_pkg::ctl_sts_type sts,
   output mspt_pkg::ctl_cmd_type cmd
);
   import mspt_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_FIND   = 7'b0000100,
      ST_RESP   = 7'b0001000,
      ST_FULL   = 7'b0010000,
      ST_SCAN   = 7'b0100000,
      ST_FLUSH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      fire;
   logic      blocked;

   assign fire      = sts.cur_valid && sts.expired;
   // a second expiry needs the output register to take the one held back
   assign blocked   = fire && sts.hold_valid && !sts.out_free;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.action)
               ACT_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = sts.paused ? ST_IDLE : ST_SCAN;
               end
               ACT_ARM_ONCE, ACT_ARM_PERIODIC: begin
                  state_in = ST_FIND;
               end
               ACT_CLEAR: begin
                  cmd.clear_slot = 1'b1;
                  state_in       = ST_RESP;
               end
               ACT_PAUSE: begin
                  cmd.set_pause = 1'b1;
                  state_in      = ST_RESP;
               end
               ACT_RESUME: begin
                  cmd.clr_pause = 1'b1;
                  state_in      = ST_RESP;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FIND: begin
            if (!sts.cur_valid) begin
               cmd.arm_write = 1'b1;
               state_in      = ST_RESP;
            end else if (sts.idx_last) begin
               state_in = ST_FULL;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_ACK;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FULL: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_FULL;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!blocked) begin
               if (fire) begin
                  cmd.scan_fire = 1'b1;
                  if (sts.hold_valid) begin
                     cmd.out_load      = 1'b1;
                     cmd.out_from_hold = 1'b1;
                     cmd.out_kind      = KIND_FIRED;
                  end
               end
               if (sts.idx_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.idx_next = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.hold_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_from_hold = 1'b1;
               cmd.out_kind      = KIND_FIRED;
               cmd.out_last      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_IMP(a_load_only_free, clock, reset, cmd.out_load, sts.out_free)
   `ASSERT_IMP(a_arm_free_slot, clock, reset, cmd.arm_write, !sts.cur_valid)
   `ASSERT_IMP(a_fire_pushes_hold, clock, reset, cmd.scan_fire && sts.hold_valid, cmd.out_load)

endmodule

// ===== hw/rtl/mspt_dpath.sv =====
// datapath of the multi-slot timer: time counters, slot table, output register
// depends on mspt_pkg and assert_macros.svh; commanded by mspt_ctrl
`include "assert_macros.svh"

module mspt_dpath #(
   parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = mspt_pkg::TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mspt_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mspt_pkg::rsp_type     rsp_data,
   input  mspt_pkg::ctl_cmd_type cmd,
   output mspt_pkg::ctl_sts_type sts
);
   import mspt_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   req_type              req_ff;
   logic [TIME_BITS-1:0] clock_ff;
   logic [31:0]          elapsed_ff;
   logic                 paused_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [NUM_SLOTS-1:0] rep_ff;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic                 hold_valid_ff;
   logic [SLOT_W-1:0]    hold_slot_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic [TIME_BITS-1:0] rd_dl_ff, rd_per_ff;

   logic [TIME_BITS-1:0] dl_mem  [NUM_SLOTS];
   logic [TIME_BITS-1:0] per_mem [NUM_SLOTS];

   logic                 idx_last;
   logic [SLOT_W-1:0]    rd_addr;
   logic [TIME_BITS-1:0] per_t;
   logic [TIME_BITS-1:0] diff;
   logic                 dl_we;
   logic [TIME_BITS-1:0] dl_wdata;
   logic [7:0]           clr_wide, idx_wide, hold_wide;
   logic                 clr_ok;
   logic [3:0]           single_slot;
   logic                 out_free;
   logic                 oneshot_fire;
   logic                 count_tick;
   logic [6:0]           valid_cnt;

   assign idx_last = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
   assign idx_in   = idx_last ? '0 : idx_ff + SLOT_W'(1);
   // prefetch the next slot while the current one is evaluated
   assign rd_addr  = cmd.idx_next ? idx_in : idx_ff;
   assign per_t    = TIME_BITS'(req_ff.period_ticks);
   // wrap-safe compare: expired when clock - deadline is not negative
   assign diff     = clock_ff - rd_dl_ff;
   assign dl_we    = cmd.arm_write || (cmd.scan_fire && rep_ff[idx_ff]);
   assign dl_wdata = cmd.arm_write ? (clock_ff + per_t) : (rd_dl_ff + rd_per_ff);
   assign clr_wide = 8'(req_ff.slot_number);
   assign clr_ok   = (clr_wide < 8'(NUM_SLOTS));
   assign idx_wide = 8'(idx_ff);
   assign hold_wide = 8'(hold_slot_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign oneshot_fire = cmd.scan_fire && !rep_ff[idx_ff];
   assign count_tick   = cmd.tick && !paused_ff;
   assign valid_cnt    = 7'($countones(valid_ff));

   always_comb begin
      case (req_ff.action)
         ACT_CLEAR:                      single_slot = req_ff.slot_number;
         ACT_ARM_ONCE, ACT_ARM_PERIODIC: single_slot = idx_wide[3:0];
         default:                        single_slot = 4'd0;
      endcase
      if (cmd.out_kind == KIND_FULL) begin
         single_slot = 4'd0;
      end
   end

   assign sts.action     = req_ff.action;
   assign sts.paused     = paused_ff;
   assign sts.cur_valid  = valid_ff[idx_ff];
   assign sts.expired    = !diff[TIME_BITS-1];
   assign sts.idx_last   = idx_last;
   assign sts.hold_valid = hold_valid_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // slot table memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[idx_ff] <= dl_wdata;
      end
      if (cmd.arm_write) begin
         per_mem[idx_ff] <= per_t;
      end
      rd_dl_ff  <= dl_mem[rd_addr];
      rd_per_ff <= per_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.arm_write) begin
         rep_ff[idx_ff] <= (req_ff.action == ACT_ARM_PERIODIC);
      end
      if (cmd.scan_fire) begin
         hold_slot_ff <= idx_ff;
      end
      if (cmd.out_load) begin
         rsp_ff.kind          <= cmd.out_kind;
         rsp_ff.slot_id       <= cmd.out_from_hold ? hold_wide[3:0] : single_slot;
         rsp_ff.elapsed_ticks <= elapsed_ff;
         rsp_ff.last          <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff      <= '0;
         elapsed_ff    <= '0;
         paused_ff     <= 1'b0;
         valid_ff      <= '0;
         idx_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.tick) begin
            clock_ff <= clock_ff + TIME_BITS'(1);
            if (!paused_ff) begin
               elapsed_ff <= elapsed_ff + 32'd1;
            end
         end
         if (cmd.set_pause) begin
            paused_ff <= 1'b1;
         end else if (cmd.clr_pause) begin
            paused_ff <= 1'b0;
         end
         if (cmd.clear_slot && clr_ok) begin
            valid_ff[clr_wide[SLOT_W-1:0]] <= 1'b0;
         end
         if (cmd.arm_write) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (oneshot_fire) begin
            valid_ff[idx_ff] <= 1'b0;
         end
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.idx_next) begin
            idx_ff <= idx_in;
         end
         if (cmd.load) begin
            hold_valid_ff <= 1'b0;
         end else if (cmd.scan_fire) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.out_load && cmd.out_from_hold && cmd.out_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `ASSERT_NXT(a_arm_takes_slot, clock, reset, cmd.arm_write, valid_cnt == $past(valid_cnt) + 7'd1)
   `ASSERT_NXT(a_oneshot_frees, clock, reset, oneshot_fire, valid_cnt + 7'd1 == $past(valid_cnt))
   `ASSERT_NXT(a_elapsed_step, clock, reset, count_tick, elapsed_ff == $past(elapsed_ff) + 32'd1)

endmodule
